@@ rtl/sgaa_pkg.sv @@
// Package for the semi-global affine alignment unit: shared types and constants.
// Used by sgaa_ctrl, sgaa_datapath and the top level; depends on nothing.
package sgaa_pkg;

   localparam int SCORE_W = 32;
   localparam int SYM_W   = 5;
   localparam int TVAL_W  = 8;
   localparam int PEN_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int END_Q_W = 10;
   localparam int END_R_W = 16;
   localparam int STAT_W  = 2;

   // Lower bound far below any reachable score, so one subtraction never wraps.
   localparam logic signed [SCORE_W-1:0] NEG_INF = -(32'sd1 <<< 30);

   typedef enum logic [1:0] {
      OP_TABLE = 2'd0,
      OP_QUERY = 2'd1,
      OP_REF   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP_OPEN    = 3'd0,
      CSR_GAP_EXTEND  = 3'd1,
      CSR_QUERY_BEGIN = 3'd2,
      CSR_QUERY_END   = 3'd3,
      CSR_REF_BEGIN   = 3'd4,
      CSR_REF_END     = 3'd5,
      CSR_RSVD6       = 3'd6,
      CSR_RSVD7       = 3'd7
   } csr_idx_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_LIMIT = 2'd2,
      STAT_RSVD  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_RDQ, ST_RDT, ST_CALC, ST_COLEND, ST_FIN
   } state_type;

   typedef struct packed {
      logic accept;   // an input transfer happens this cycle
      logic setup;    // prepare boundary values for a new column
      logic rdt;      // query symbol is back, look up the table
      logic calc;     // compute and write one cell
      logic colend;   // close the column
      logic fin;      // load the result registers
   } cmd_type;

   typedef struct packed {
      logic ref_full;
      logic query_empty;
      logic last_cell;
   } stat_type;

endpackage

@@ rtl/semi_global_affine_alignment_unit.sv @@
// Top level of the semi-global affine alignment unit.
// Depends on sgaa_pkg, sgaa_ctrl and sgaa_datapath.
//
// Usage: load substitution entries (operation 0) and query symbols (operation 1),
// then stream reference symbols (operation 2); the symbol with is_last set yields
// one result with the score, the end positions and a status. A reference symbol
// sets up its column and computes the cells one at a time, taking no new transfer
// meanwhile: each cell waits for the registered read of the query memory followed
// by the registered read of the substitution table feeding the cell. A reference
// symbol past the length limit is dropped. The last symbol then loads the result
// register, and waits while an earlier result has not yet been taken; the next
// transfer is taken while a result still waits.
// Configuration is to be written only while the unit is idle; the unit itself
// does not enforce this.
module semi_global_affine_alignment_unit #(
   parameter int MAX_QUERY = 1024,
   parameter int MAX_REF   = 65536,
   parameter int ALPHABET  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [sgaa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgaa_pkg::PEN_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_symbol,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_table_row,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_table_col,
   input  logic signed [sgaa_pkg::TVAL_W-1:0] req_table_value,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [sgaa_pkg::SCORE_W-1:0] rsp_score,
   output logic [sgaa_pkg::END_Q_W-1:0]    rsp_query_pos,
   output logic [sgaa_pkg::END_R_W-1:0]    rsp_end_ref,
   output logic [sgaa_pkg::STAT_W-1:0]     rsp_status
);
   import sgaa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes and sequences each column.
   sgaa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .stat          (stat)
   );

   // The datapath holds the memories, the cell arithmetic and the result.
   sgaa_datapath #(
      .MAX_QUERY (MAX_QUERY),
      .MAX_REF   (MAX_REF),
      .ALPHABET  (ALPHABET)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_table_row   (req_table_row),
      .req_table_col   (req_table_col),
      .req_table_value (req_table_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_score       (rsp_score),
      .rsp_query_pos   (rsp_query_pos),
      .rsp_end_ref     (rsp_end_ref),
      .rsp_status      (rsp_status)
   );

endmodule

@@ rtl/sgaa_ctrl.sv @@
// Controller state machine for the semi-global affine alignment unit.
// Depends on sgaa_pkg; drives the datapath through cmd_type and reads stat_type.
module sgaa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_operation,
   input  logic             req_is_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgaa_pkg::cmd_type cmd,
   input  sgaa_pkg::stat_type stat
);
   import sgaa_pkg::*;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign acc       = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = acc;
            if (acc && op_type'(req_operation) == OP_REF) begin
               last_in = req_is_last;
               if (!stat.ref_full) begin
                  state_in = ST_SETUP;
               end else if (req_is_last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = stat.query_empty ? ST_COLEND : ST_RDQ;
         end
         ST_RDQ: begin
            state_in = ST_RDT;
         end
         ST_RDT: begin
            cmd.rdt  = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = stat.last_cell ? ST_COLEND : ST_RDQ;
         end
         ST_COLEND: begin
            cmd.colend = 1'b1;
            state_in   = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/sgaa_datapath.sv @@
// Datapath of the semi-global affine alignment unit: memories, DP cell, result.
// Depends on sgaa_pkg; sequenced by sgaa_ctrl through cmd_type.
module sgaa_datapath #(
   parameter int MAX_QUERY = 1024,
   parameter int MAX_REF   = 65536,
   parameter int ALPHABET  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [sgaa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgaa_pkg::PEN_W-1:0]      csr_wdata,
   input  logic [1:0]                      req_operation,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_symbol,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_table_row,
   input  logic [sgaa_pkg::SYM_W-1:0]      req_table_col,
   input  logic signed [sgaa_pkg::TVAL_W-1:0] req_table_value,
   input  sgaa_pkg::cmd_type               cmd,
   output sgaa_pkg::stat_type              stat,
   output logic signed [sgaa_pkg::SCORE_W-1:0] rsp_score,
   output logic [sgaa_pkg::END_Q_W-1:0]    rsp_query_pos,
   output logic [sgaa_pkg::END_R_W-1:0]    rsp_end_ref,
   output logic [sgaa_pkg::STAT_W-1:0]     rsp_status
);
   import sgaa_pkg::*;

   localparam int QW  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int QCW = $clog2(MAX_QUERY + 1);
   localparam int RW  = $clog2(MAX_REF + 1);
   localparam int TD  = ALPHABET * ALPHABET;
   localparam int TAW = $clog2(TD);

   typedef logic signed [SCORE_W-1:0] sc_type;

   function automatic sc_type smax(input sc_type a, input sc_type b);
      return (a > b) ? a : b;
   endfunction

   // Configuration registers.
   logic [PEN_W-1:0] open_ff, ext_ff;
   logic qbf_ff, qef_ff, rbf_ff, ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= PEN_W'(10);
         ext_ff  <= PEN_W'(1);
         qbf_ff  <= 1'b0;
         qef_ff  <= 1'b0;
         rbf_ff  <= 1'b0;
         ref_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_GAP_OPEN:    open_ff <= csr_wdata;
            CSR_GAP_EXTEND:  ext_ff  <= csr_wdata;
            CSR_QUERY_BEGIN: qbf_ff  <= csr_wdata[0];
            CSR_QUERY_END:   qef_ff  <= csr_wdata[0];
            CSR_REF_BEGIN:   rbf_ff  <= csr_wdata[0];
            CSR_REF_END:     ref_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   sc_type open_s, ext_s;
   assign open_s = sc_type'({1'b0, open_ff});
   assign ext_s  = sc_type'({1'b0, ext_ff});

   // Memories.
   logic [TVAL_W-1:0]  tbl_mem [TD];
   logic [SYM_W-1:0]   q_mem   [MAX_QUERY];
   sc_type             h_mem   [MAX_QUERY];
   sc_type             e_mem   [MAX_QUERY];
   logic [TVAL_W-1:0]  tbl_rd;
   logic [SYM_W-1:0]   q_rd;
   sc_type             h_rd, e_rd;

   // Control and column state.
   logic [QCW-1:0] qcount_ff, qcount_in;
   logic [RW-1:0]  rcount_ff;
   logic [QW-1:0]  idx_ff;
   logic           qover_ff, rover_ff, sealed_ff;
   logic [SYM_W-1:0] rsym_ff;
   sc_type diag_ff, north_ff, f_ff, colmax_ff, hlast_ff, best_ff, init_h_ff;
   logic [QW-1:0]  colpos_ff;
   logic [RW-1:0]  bestpos_ff;
   logic           sub_ok_ff;

   logic op_tbl, op_q, op_r, tbl_wr, q_wr;
   logic [QCW-1:0] eff_count;
   logic [TAW-1:0] tbl_waddr, tbl_raddr;

   assign op_tbl = cmd.accept && op_type'(req_operation) == OP_TABLE;
   assign op_q   = cmd.accept && op_type'(req_operation) == OP_QUERY && rcount_ff == '0;
   assign op_r   = cmd.accept && op_type'(req_operation) == OP_REF;
   assign tbl_wr = op_tbl && (32'(req_table_row) < ALPHABET) && (32'(req_table_col) < ALPHABET);
   assign eff_count = sealed_ff ? '0 : qcount_ff;
   assign q_wr   = op_q && (32'(eff_count) < MAX_QUERY);
   assign tbl_waddr = TAW'(32'(req_table_row) * ALPHABET + 32'(req_table_col));
   assign tbl_raddr = TAW'(32'(q_rd) * ALPHABET + 32'(rsym_ff));

   always_ff @(posedge clock) begin
      if (tbl_wr) tbl_mem[tbl_waddr] <= req_table_value;
      tbl_rd <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_wr) q_mem[eff_count[QW-1:0]] <= req_symbol;
      q_rd <= q_mem[idx_ff];
   end

   // Cell arithmetic.
   sc_type left, eprev, e_new, f_new, h_new, sub;
   sc_type top_j, top_jm1, init_h;
   logic [RW-1:0] rlen_m1;

   assign left  = (rcount_ff == '0) ? init_h_ff : h_rd;
   assign eprev = (rcount_ff == '0) ? NEG_INF : e_rd;
   assign sub   = sub_ok_ff ? sc_type'($signed(tbl_rd)) : '0;
   assign e_new = smax(left - open_s, eprev - ext_s);
   assign f_new = smax(north_ff - open_s, f_ff - ext_s);
   assign h_new = smax(smax(diag_ff + sub, e_new), f_new);

   // Boundary products are formed at full score width so they never wrap.
   assign top_j   = rbf_ff ? '0 : -open_s - sc_type'(rcount_ff) * ext_s;
   assign top_jm1 = (rcount_ff == '0 || rbf_ff) ? '0
                    : -open_s - sc_type'(rcount_ff - RW'(1)) * ext_s;
   assign init_h  = qbf_ff ? '0 : -open_s - sc_type'(idx_ff) * ext_s;
   assign rlen_m1 = rcount_ff - RW'(1);

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         h_mem[idx_ff] <= h_new;
         e_mem[idx_ff] <= e_new;
      end
      h_rd <= h_mem[idx_ff];
      e_rd <= e_mem[idx_ff];
   end

   assign stat.ref_full    = (32'(rcount_ff) >= MAX_REF);
   assign stat.query_empty = (qcount_ff == '0);
   assign stat.last_cell   = (QCW'(idx_ff) + QCW'(1) == qcount_ff);

   always_comb begin
      qcount_in = qcount_ff;
      if (q_wr) qcount_in = eff_count + QCW'(1);
      else if (op_q && sealed_ff) qcount_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcount_ff  <= '0;
         rcount_ff  <= '0;
         qover_ff   <= 1'b0;
         rover_ff   <= 1'b0;
         sealed_ff  <= 1'b0;
         best_ff    <= NEG_INF;
         bestpos_ff <= '0;
         idx_ff     <= '0;
      end else begin
         qcount_ff <= qcount_in;
         if (op_q) qover_ff <= (sealed_ff ? 1'b0 : qover_ff) | !q_wr;
         if (op_q) sealed_ff <= 1'b0;
         if (op_r) begin
            sealed_ff <= 1'b1;
            rsym_ff   <= req_symbol;
            if (stat.ref_full) rover_ff <= 1'b1;
         end
         if (cmd.setup) idx_ff <= '0;
         if (cmd.calc && !stat.last_cell) idx_ff <= idx_ff + QW'(1);
         if (cmd.colend) begin
            rcount_ff <= rcount_ff + RW'(1);
            if (north_ff > best_ff) begin
               best_ff    <= north_ff;
               bestpos_ff <= rcount_ff;
            end
         end
         if (cmd.fin) begin
            rcount_ff  <= '0;
            rover_ff   <= 1'b0;
            best_ff    <= NEG_INF;
            bestpos_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         diag_ff   <= top_jm1;
         north_ff  <= top_j;
         f_ff      <= NEG_INF;
         colmax_ff <= NEG_INF;
      end
      if (cmd.rdt) begin
         init_h_ff <= init_h;
         sub_ok_ff <= (32'(q_rd) < ALPHABET) && (32'(rsym_ff) < ALPHABET);
      end
      if (cmd.calc) begin
         diag_ff  <= left;
         north_ff <= h_new;
         f_ff     <= f_new;
         if (h_new > colmax_ff) begin
            colmax_ff <= h_new;
            colpos_ff <= idx_ff;
         end
         if (stat.last_cell) hlast_ff <= h_new;
      end
   end

   // Result selection by the end flags.
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         if (qcount_ff == '0) begin
            rsp_score     <= '0;
            rsp_query_pos <= '0;
            rsp_end_ref   <= '0;
            rsp_status    <= STAT_EMPTY;
         end else begin
            if (qef_ff && (!ref_ff || colmax_ff > best_ff
                           || (colmax_ff == best_ff && bestpos_ff == rlen_m1))) begin
               rsp_score     <= colmax_ff;
               rsp_query_pos <= END_Q_W'(colpos_ff);
               rsp_end_ref   <= END_R_W'(rlen_m1);
            end else if (ref_ff) begin
               rsp_score     <= best_ff;
               rsp_query_pos <= END_Q_W'(qcount_ff - QCW'(1));
               rsp_end_ref   <= END_R_W'(bestpos_ff);
            end else begin
               rsp_score     <= hlast_ff;
               rsp_query_pos <= END_Q_W'(qcount_ff - QCW'(1));
               rsp_end_ref   <= END_R_W'(rlen_m1);
            end
            rsp_status <= (qover_ff || rover_ff) ? STAT_LIMIT : STAT_OK;
         end
      end
   end

endmodule

@@ tb/tb.sv @@
// Testbench for the semi-global affine alignment unit: score predictor, scoreboard and stimulus.
// Depends on sgaa_pkg and the semi_global_affine_alignment_unit top level.
`timescale 1ns / 100ps

module tb;
   import sgaa_pkg::*;

   typedef struct {
      logic signed [31:0] score;
      logic [9:0]         end_q;
      logic [15:0]        end_r;
      logic [1:0]         status;
   } align_result_type;

   // Tracks table, query and DP columns and queues the expected alignment results.
   class align_scoreboard;
      localparam longint FLOOR = -(64'sd1 <<< 62);
      localparam int QMAX = 1024;
      localparam int RMAX = 65536;
      localparam int NSYM = 24;

      byte              subst_tab [NSYM*NSYM];
      logic [4:0]       query_sym [QMAX];
      int unsigned      query_len;
      int unsigned      ref_len;
      longint           col_h [QMAX];
      longint           col_e [QMAX];
      longint           row_best;
      int unsigned      row_best_pos;
      bit               query_over, ref_over, query_sealed;
      longint           gap_open, gap_ext;
      bit               q_begin_free, q_end_free, r_begin_free, r_end_free;
      align_result_type pending_scores [$];
      int               errors;
      int               results_seen;

      function new();
         query_len = 0;
         ref_len = 0;
         row_best = FLOOR;
         row_best_pos = 0;
         query_over = 0;
         ref_over = 0;
         query_sealed = 0;
         gap_open = 10;
         gap_ext = 1;
         q_begin_free = 0;
         q_end_free = 0;
         r_begin_free = 0;
         r_end_free = 0;
         errors = 0;
         results_seen = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [7:0] v);
         case (idx)
            CSR_GAP_OPEN:    gap_open = longint'(v);
            CSR_GAP_EXTEND:  gap_ext = longint'(v);
            CSR_QUERY_BEGIN: q_begin_free = v[0];
            CSR_QUERY_END:   q_end_free = v[0];
            CSR_REF_BEGIN:   r_begin_free = v[0];
            CSR_REF_END:     r_end_free = v[0];
            default: ;
         endcase
      endfunction

      function longint max2(longint a, longint b);
         return (a > b) ? a : b;
      endfunction

      function longint top_val(int unsigned j);
         return r_begin_free ? 64'sd0 : -gap_open - longint'(j) * gap_ext;
      endfunction

      function longint subst(logic [4:0] q, logic [4:0] r);
         if (q >= NSYM || r >= NSYM) return 0;
         return longint'(subst_tab[q*NSYM + r]);
      endfunction

      // Advance the DP by one reference column.
      function void add_column(logic [4:0] r);
         longint diag, north, f, left, e, h;
         int unsigned j;
         j = ref_len;
         if (j == 0) begin
            for (int i = 0; i < query_len; i++) begin
               col_h[i] = q_begin_free ? 64'sd0 : -gap_open - longint'(i) * gap_ext;
               col_e[i] = FLOOR;
            end
            row_best = FLOOR;
            row_best_pos = 0;
         end
         diag = (j == 0) ? 64'sd0 : top_val(j - 1);
         north = top_val(j);
         f = FLOOR;
         for (int i = 0; i < query_len; i++) begin
            left = col_h[i];
            e = max2(left - gap_open, col_e[i] - gap_ext);
            f = max2(north - gap_open, f - gap_ext);
            h = max2(max2(diag + subst(query_sym[i], r), e), f);
            diag = left;
            north = h;
            col_h[i] = h;
            col_e[i] = e;
         end
         if (north > row_best) begin
            row_best = north;
            row_best_pos = j;
         end
      endfunction

      function void take_item(op_type op, logic [4:0] sym, logic [4:0] row, logic [4:0] col,
                              logic [7:0] val, logic last);
         align_result_type res;
         longint score, max_col;
         int unsigned eq, er, col_pos;
         case (op)
            OP_TABLE: begin
               if (row < NSYM && col < NSYM) subst_tab[row*NSYM + col] = byte'(val);
               return;
            end
            OP_QUERY: begin
               if (ref_len != 0) return;
               if (query_sealed) begin
                  query_len = 0;
                  query_over = 0;
                  query_sealed = 0;
               end
               if (query_len < QMAX) begin
                  query_sym[query_len] = sym;
                  query_len++;
               end else begin
                  query_over = 1;
               end
               return;
            end
            OP_REF: ;
            default: return;
         endcase
         query_sealed = 1;
         if (ref_len < RMAX) begin
            add_column(sym);
            ref_len++;
         end else begin
            ref_over = 1;
         end
         if (!last) return;
         if (query_len == 0) begin
            score = 0;
            eq = 0;
            er = 0;
            res.status = STAT_EMPTY;
         end else begin
            max_col = FLOOR;
            col_pos = 0;
            for (int i = 0; i < query_len; i++) begin
               if (col_h[i] > max_col) begin
                  max_col = col_h[i];
                  col_pos = i;
               end
            end
            // With both ends free the column wins ties only when the row's best sits at the end.
            if (q_end_free && (!r_end_free || max_col > row_best ||
                (max_col == row_best && row_best_pos == ref_len - 1))) begin
               score = max_col;
               eq = col_pos;
               er = ref_len - 1;
            end else if (r_end_free) begin
               score = row_best;
               eq = query_len - 1;
               er = row_best_pos;
            end else begin
               score = col_h[query_len - 1];
               eq = query_len - 1;
               er = ref_len - 1;
            end
            res.status = (query_over || ref_over) ? STAT_LIMIT : STAT_OK;
         end
         res.score = score[31:0];
         res.end_q = eq[9:0];
         res.end_r = er[15:0];
         pending_scores.push_back(res);
         ref_len = 0;
         ref_over = 0;
         row_best = FLOOR;
         row_best_pos = 0;
      endfunction

      function void check_score(logic signed [31:0] score, logic [9:0] eq, logic [15:0] er,
                                logic [1:0] st);
         align_result_type exp_res;
         results_seen++;
         if (pending_scores.size() == 0) begin
            $error("alignment result with none expected: score %0d", score);
            errors++;
            return;
         end
         exp_res = pending_scores.pop_front();
         if (score !== exp_res.score) begin
            $error("score: expected %0d, got %0d", exp_res.score, score);
            errors++;
         end
         if (eq !== exp_res.end_q) begin
            $error("query_pos: expected %0d, got %0d", exp_res.end_q, eq);
            errors++;
         end
         if (er !== exp_res.end_r) begin
            $error("end_ref: expected %0d, got %0d", exp_res.end_r, er);
            errors++;
         end
         if (st !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, st);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = '0;
   logic [4:0]  req_symbol = '0;
   logic [4:0]  req_table_row = '0;
   logic [4:0]  req_table_col = '0;
   logic signed [7:0] req_table_value = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_score;
   logic [9:0]  rsp_query_pos;
   logic [15:0] rsp_end_ref;
   logic [1:0]  rsp_status;

   align_scoreboard sb = new();

   // When calm is set neither side inserts idle cycles.
   bit calm = 1'b0;
   int requests_sent = 0;
   int random_items = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   semi_global_affine_alignment_unit dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_symbol(req_symbol), .req_table_row(req_table_row),
      .req_table_col(req_table_col), .req_table_value(req_table_value),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_score(rsp_score),
      .rsp_query_pos(rsp_query_pos), .rsp_end_ref(rsp_end_ref), .rsp_status(rsp_status)
   );

   // Transfers are observed at the rising edge, before the design's own updates land.
   // The watchdog counts edges at which neither channel completes a transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.take_item(op_type'(req_operation), req_symbol, req_table_row, req_table_col,
                         req_table_value, req_is_last);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_score(rsp_score, rsp_query_pos, rsp_end_ref, rsp_status);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Result side: unless calm is set, hold ready low for a random number of cycles before each transfer.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 7);
         rsp_ready = 1'b0;
         repeat (hold) @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // One request transfer; the fields change only at the falling edge.
   task automatic send_item(op_type op, logic [4:0] sym, logic [4:0] row, logic [4:0] col,
                            logic [7:0] val, logic last);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_operation = op;
      req_symbol = sym;
      req_table_row = row;
      req_table_col = col;
      req_table_value = val;
      req_is_last = last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic write_csr(csr_idx_type idx, logic [7:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_write = 1'b1;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // Let every expected result drain, then let a possible column in flight finish.
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (sb.pending_scores.size() != 0) @(negedge clock);
      repeat (3 * sb.query_len + 20) @(negedge clock);
   endtask

   task automatic set_gaps(logic [7:0] op_pen, logic [7:0] ext_pen, logic [3:0] flags);
      wait_quiet();
      write_csr(CSR_GAP_OPEN, op_pen);
      write_csr(CSR_GAP_EXTEND, ext_pen);
      write_csr(CSR_QUERY_BEGIN, {7'd0, flags[0]});
      write_csr(CSR_QUERY_END, {7'd0, flags[1]});
      write_csr(CSR_REF_BEGIN, {7'd0, flags[2]});
      write_csr(CSR_REF_END, {7'd0, flags[3]});
      settings_used++;
   endtask

   // Mostly residues from the loaded part of the table, sometimes ones past the
   // alphabet that score zero.
   function automatic logic [4:0] pick_sym();
      return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                         : 5'($urandom_range(0, 7));
   endfunction

   // A stray item: an unknown operation (no effect), a query symbol or a table load.
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0: send_item(OP_NONE, 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
                      1'($urandom));
         1: send_item(OP_QUERY, pick_sym(), 5'($urandom), 5'($urandom), 8'($urandom),
                      1'($urandom));
         2: send_item(OP_TABLE, 5'($urandom), 5'($urandom), 5'($urandom_range(0, 31)),
                      8'($urandom), 1'($urandom));
         default: send_item(OP_TABLE, 5'($urandom), 5'($urandom_range(0, 23)),
                            5'($urandom_range(0, 23)), 8'($urandom), 1'b1);
      endcase
   endtask

   // A fresh query followed by one reference stream that ends in a result.
   task automatic run_alignment(int qlen, int rlen, bit noisy);
      for (int i = 0; i < qlen; i++) begin
         send_item(OP_QUERY, pick_sym(), 5'($urandom), 5'($urandom), 8'($urandom),
                   1'($urandom));
         random_items++;
      end
      for (int j = 0; j < rlen; j++) begin
         if (noisy && $urandom_range(0, 5) == 0) send_noise();
         send_item(OP_REF, pick_sym(), 5'($urandom), 5'($urandom), 8'($urandom),
                   (j == rlen - 1));
         random_items++;
      end
   endtask

   initial begin
      int qlen, rlen;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // An empty query yields the empty status with zero score and positions.
      send_item(OP_REF, 5'd3, 5'd0, 5'd0, 8'd0, 1'b1);

      // Fill the part of the table that the residues used here can read.
      calm = 1'b1;
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++)
            send_item(OP_TABLE, 5'($urandom), 5'(r), 5'(c), 8'($urandom), 1'b0);
      calm = 1'b0;

      // Extreme table values, ignored loads past the alphabet, an unknown operation and a query.
      send_item(OP_TABLE, 5'd0, 5'd0, 5'd0, 8'h7f, 1'b0);
      send_item(OP_TABLE, 5'd0, 5'd7, 5'd7, 8'h80, 1'b1);
      send_item(OP_TABLE, 5'd0, 5'd24, 5'd3, 8'h55, 1'b0);
      send_item(OP_TABLE, 5'd0, 5'd2, 5'd31, 8'haa, 1'b0);
      send_item(OP_NONE, 5'd31, 5'd31, 5'd31, 8'hff, 1'b1);
      send_item(OP_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 1'b1);
      send_item(OP_QUERY, 5'd7, 5'd0, 5'd0, 8'd0, 1'b0);
      send_item(OP_QUERY, 5'd31, 5'd0, 5'd0, 8'd0, 1'b0);
      send_item(OP_QUERY, 5'd0, 5'd0, 5'd0, 8'd0, 1'b0);
      send_item(OP_REF, 5'd0, 5'd0, 5'd0, 8'd0, 1'b0);
      // A query symbol in the middle of a reference stream is dropped.
      send_item(OP_QUERY, 5'd7, 5'd0, 5'd0, 8'd0, 1'b0);
      send_item(OP_REF, 5'd7, 5'd0, 5'd0, 8'd0, 1'b0);
      send_item(OP_NONE, 5'd1, 5'd0, 5'd0, 8'd0, 1'b1);
      send_item(OP_REF, 5'd31, 5'd0, 5'd0, 8'd0, 1'b1);
      // After a result the stream restarts on the same query.
      send_item(OP_REF, 5'd7, 5'd0, 5'd0, 8'd0, 1'b1);

      // Random phases; the first few gap settings are the extremes.
      for (int ph = 0; random_items < 600; ph++) begin
         case (ph)
            0: set_gaps(8'd0, 8'd0, 4'b0000);
            1: set_gaps(8'd255, 8'd255, 4'b1111);
            2: set_gaps(8'd255, 8'd0, 4'b1001);
            3: set_gaps(8'd0, 8'd255, 4'b0110);
            default: set_gaps(8'($urandom), 8'($urandom_range(0, 20)), 4'($urandom));
         endcase
         calm = (ph % 3 == 2);
         for (int k = 0; k < 8; k++) begin
            qlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            run_alignment(qlen, rlen, ($urandom_range(0, 3) != 0));
         end
      end

      wait_quiet();
      $display("Sent %0d requests and checked %0d alignment results", requests_sent,
               sb.results_seen);
      $display("under %0d gap and end-mode settings, with stray and ignored items mixed in",
               settings_used);
      if (sb.errors == 0 && sb.pending_scores.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
